### rtl/ptw_pkg.sv
`timescale 1ns / 1ps

package ptw_pkg;

   // defaults for the top-level parameters
   localparam int TABLE_PAGES_DEF = 64;
   localparam int FRAME_BITS_DEF  = 40;

   // fixed field widths
   localparam int CMD_W        = 2;
   localparam int STATUS_W     = 2;
   localparam int VA_W         = 48;
   localparam int PA_W         = 52;
   localparam int ROOT_W       = 6;
   localparam int FIRST_FREE_W = 7;
   localparam int IDX_BITS     = 9;
   localparam int OFFSET_BITS  = 12;
   localparam int LEVELS       = 4;
   localparam int LEVEL_W      = 2;

   // entry layout
   localparam int BIT_PRESENT  = 0;
   localparam int BIT_WRITABLE = 1;
   localparam int BIT_USER     = 2;
   localparam int FRAME_LSB    = 3;

   // csr port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_ROOT_PAGE       = 1'b0;
   localparam logic REG_FIRST_FREE_PAGE = 1'b1;
   localparam logic [FIRST_FREE_W-1:0] FIRST_FREE_RST = 7'd1;

   // command codes
   localparam logic [CMD_W-1:0] CMD_TRANSLATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MAP       = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MARK_USER = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE      = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED   = 2'd2;

   // what the level evaluator tells the sequencer
   typedef struct packed {
      logic                wr_en;
      logic                alloc;
      logic                done;
      logic [STATUS_W-1:0] status;
   } step_ctrl_type;

endpackage

### rtl/four_level_page_table_walker.sv
`timescale 1ns / 1ps

// Four-level page table walker over a local table store of TABLE_PAGES pages
// of 512 entries (entry: bit 0 present, bit 1 writable, bit 2 user, frame
// above). req_tuser carries the command (translate, map, mark user), req_tdata
// the virtual address and, for map, the physical address; each command gives
// exactly one response transfer with the physical address and a status. The
// walk visits one level at a time through the one read port and one write
// port of the store (address, then registered read data plus write-back): a
// command is taken in idle, each of up to four levels passes through read and
// eval, and done hands the result to the output register, waiting while it is
// full and not taken; a missing entry ends the walk early, and the unused
// command skips the walk and goes straight to done. After reset the store is
// cleared one entry per cycle, during which req_tready stays low; csr writes
// are taken all the time. Writing first_free_page also restarts the page
// allocator there.
module four_level_page_table_walker #(
   parameter int TABLE_PAGES = ptw_pkg::TABLE_PAGES_DEF,
   parameter int FRAME_BITS  = ptw_pkg::FRAME_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: tdata = virt_addr[47:0], phys_addr[99:48], zero pad to 104
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [103:0]                        req_tdata,
   // request: tuser = cmd[1:0]
   input  logic [ptw_pkg::CMD_W-1:0]           req_tuser,
   // response: tdata = phys_addr_out[51:0], zero pad to 56
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [55:0]                         rsp_tdata,
   // response: tuser = status[1:0]
   output logic [ptw_pkg::STATUS_W-1:0]        rsp_tuser,
   // csr port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ptw_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ptw_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ptw_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import ptw_pkg::*;

   localparam int EW     = FRAME_BITS + 3;
   localparam int PAGE_W = $clog2(TABLE_PAGES);
   localparam int DEPTH  = TABLE_PAGES * 512;
   localparam int ADDR_W = PAGE_W + IDX_BITS;
   localparam int NF_W   = ($clog2(TABLE_PAGES + 1) > FIRST_FREE_W) ?
                           $clog2(TABLE_PAGES + 1) : FIRST_FREE_W;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   // sequencer and walk state
   logic [2:0]             state_ff, state_in;
   logic [ADDR_W-1:0]      clr_ff, clr_in;
   logic [CMD_W-1:0]       cmd_ff, cmd_in;
   logic [VA_W-1:0]        va_ff, va_in;
   logic [FRAME_BITS-1:0]  pa_ff, pa_in;
   logic [PAGE_W-1:0]      page_ff, page_in;
   logic [LEVEL_W-1:0]     level_ff, level_in;
   logic [PA_W-1:0]        res_ff, res_in;
   logic [STATUS_W-1:0]    stat_ff, stat_in;
   // configuration and allocator
   logic [ROOT_W-1:0]       root_ff, root_in;
   logic [FIRST_FREE_W-1:0] first_free_ff, first_free_in;
   logic [NF_W-1:0]         next_free_ff, next_free_in;
   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PA_W-1:0]        rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]    rsp_stat_ff, rsp_stat_in;

   logic                   req_xfer;
   logic                   csr_wr;
   logic [IDX_BITS-1:0]    idx;
   logic [ADDR_W-1:0]      walk_addr;
   logic                   ram_we;
   logic [ADDR_W-1:0]      ram_waddr;
   logic [EW-1:0]          ram_wdata;
   logic                   ram_re;
   logic [EW-1:0]          ram_rdata;
   step_ctrl_type          step_ctrl;
   logic [EW-1:0]          step_wr_entry;
   logic [PAGE_W-1:0]      step_next_page;
   logic [PA_W-1:0]        step_result;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_data_ff};
   assign rsp_tuser  = rsp_stat_ff;

   // csr readback
   always_comb begin
      case (csr_paddr[2])
         REG_ROOT_PAGE:       csr_prdata = CSR_DATA_W'(root_ff);
         REG_FIRST_FREE_PAGE: csr_prdata = CSR_DATA_W'(first_free_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // index of the current level, top level first
   always_comb begin
      case (level_ff)
         2'd0:    idx = va_ff[OFFSET_BITS + 3 * IDX_BITS +: IDX_BITS];
         2'd1:    idx = va_ff[OFFSET_BITS + 2 * IDX_BITS +: IDX_BITS];
         2'd2:    idx = va_ff[OFFSET_BITS + IDX_BITS +: IDX_BITS];
         default: idx = va_ff[OFFSET_BITS +: IDX_BITS];
      endcase
   end

   assign walk_addr = {page_ff, idx};

   // store port: clearing sweep after reset, else the walk
   always_comb begin
      if (state_ff == S_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = (state_ff == S_EVAL) & step_ctrl.wr_en;
         ram_waddr = walk_addr;
         ram_wdata = step_wr_entry;
      end
   end

   assign ram_re = (state_ff == S_READ);

   ptw_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (walk_addr),
      .rdata (ram_rdata)
   );

   // one level of the walk, reused for every level
   ptw_step #(
      .TABLE_PAGES (TABLE_PAGES),
      .FRAME_BITS  (FRAME_BITS),
      .NF_W        (NF_W),
      .PAGE_W      (PAGE_W)
   ) u_step (
      .cmd       (cmd_ff),
      .leaf      (level_ff == LEVEL_W'(LEVELS - 1)),
      .entry     (ram_rdata),
      .next_free (next_free_ff),
      .pa_frame  (pa_ff),
      .va_offset (va_ff[OFFSET_BITS-1:0]),
      .ctrl      (step_ctrl),
      .wr_entry  (step_wr_entry),
      .next_page (step_next_page),
      .result    (step_result)
   );

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      va_in         = va_ff;
      pa_in         = pa_ff;
      page_in       = page_ff;
      level_in      = level_ff;
      res_in        = res_ff;
      stat_in       = stat_ff;
      root_in       = root_ff;
      first_free_in = first_free_ff;
      next_free_in  = next_free_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_stat_in   = rsp_stat_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // csr writes, taken in any state
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_ROOT_PAGE: begin
               root_in = csr_pwdata[ROOT_W-1:0];
            end
            REG_FIRST_FREE_PAGE: begin
               first_free_in = csr_pwdata[FIRST_FREE_W-1:0];
               next_free_in  = NF_W'(csr_pwdata[FIRST_FREE_W-1:0]);
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               cmd_in   = req_tuser;
               va_in    = req_tdata[VA_W-1:0];
               pa_in    = req_tdata[VA_W + OFFSET_BITS +: FRAME_BITS];
               page_in  = PAGE_W'(root_ff);
               level_in = '0;
               res_in   = '0;
               stat_in  = ST_OK;
               if (req_tuser == CMD_NONE) begin
                  state_in = S_DONE;
               end else if (FRAME_BITS'(root_ff) >= FRAME_BITS'(TABLE_PAGES)) begin
                  // root outside the store counts as a missing entry
                  stat_in  = ST_NOT_PRESENT;
                  state_in = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (step_ctrl.alloc) begin
               next_free_in = next_free_ff + 1'b1;
            end
            if (step_ctrl.done) begin
               res_in   = step_result;
               stat_in  = step_ctrl.status;
               state_in = S_DONE;
            end else begin
               page_in  = step_next_page;
               level_in = level_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_stat_in  = stat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         root_ff       <= '0;
         first_free_ff <= FIRST_FREE_RST;
         next_free_ff  <= NF_W'(FIRST_FREE_RST);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         root_ff       <= root_in;
         first_free_ff <= first_free_in;
         next_free_ff  <= next_free_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      va_ff       <= va_in;
      pa_ff       <= pa_in;
      page_ff     <= page_in;
      level_ff    <= level_in;
      res_ff      <= res_in;
      stat_ff     <= stat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   // store writes come only from the clearing sweep or a walk write-back
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLEAR || state_ff == S_EVAL))
      else $error("store written outside sweep or write-back");

   // allocator never hands out a page beyond the store
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && step_ctrl.alloc) |-> (next_free_ff < NF_W'(TABLE_PAGES)))
      else $error("allocation past end of store");

   // allocator only moves forward, unless reloaded by a csr write
   assert property (@(posedge clock) disable iff (reset)
      !(csr_wr && csr_paddr[2] == REG_FIRST_FREE_PAGE) |=> (next_free_ff >= $past(next_free_ff)))
      else $error("allocator went backwards");

   // a response only appears when a walk has finished
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response without a finished walk");

endmodule

### rtl/ptw_ram.sv
`timescale 1ns / 1ps

module ptw_ram #(
   parameter int WIDTH = 43,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/ptw_step.sv
`timescale 1ns / 1ps

module ptw_step #(
   parameter int TABLE_PAGES = 64,
   parameter int FRAME_BITS  = 40,
   parameter int NF_W        = 7,
   parameter int PAGE_W      = 6
) (
   input  logic [ptw_pkg::CMD_W-1:0]       cmd,
   input  logic                            leaf,
   input  logic [FRAME_BITS+2:0]           entry,
   input  logic [NF_W-1:0]                 next_free,
   input  logic [FRAME_BITS-1:0]           pa_frame,
   input  logic [ptw_pkg::OFFSET_BITS-1:0] va_offset,
   output ptw_pkg::step_ctrl_type          ctrl,
   output logic [FRAME_BITS+2:0]           wr_entry,
   output logic [PAGE_W-1:0]               next_page,
   output logic [ptw_pkg::PA_W-1:0]        result
);
   import ptw_pkg::*;

   localparam int EW = FRAME_BITS + 3;

   logic [EW-1:0] eff;

   always_comb begin
      ctrl      = '0;
      eff       = entry;
      wr_entry  = entry;
      next_page = '0;
      result    = '0;
      if (leaf) begin
         ctrl.done = 1'b1;
         case (cmd)
            CMD_TRANSLATE: begin
               if (!entry[BIT_PRESENT]) begin
                  ctrl.status = ST_NOT_PRESENT;
               end else begin
                  result = PA_W'({entry[EW-1:FRAME_LSB], va_offset});
               end
            end
            CMD_MAP: begin
               ctrl.wr_en = 1'b1;
               wr_entry   = {pa_frame, entry[BIT_USER], 2'b11};
            end
            CMD_MARK_USER: begin
               ctrl.wr_en         = 1'b1;
               wr_entry[BIT_USER] = 1'b1;
            end
            default: begin
            end
         endcase
      end else begin
         if (!entry[BIT_PRESENT]) begin
            if (cmd != CMD_MAP) begin
               ctrl.done   = 1'b1;
               ctrl.status = ST_NOT_PRESENT;
            end else if (next_free >= NF_W'(TABLE_PAGES)) begin
               ctrl.done   = 1'b1;
               ctrl.status = ST_EXHAUSTED;
            end else begin
               // fresh table page; the old user flag survives
               ctrl.wr_en = 1'b1;
               ctrl.alloc = 1'b1;
               eff = {FRAME_BITS'(next_free), entry[BIT_USER], 2'b11};
            end
         end else if (cmd == CMD_MARK_USER) begin
            ctrl.wr_en    = 1'b1;
            eff[BIT_USER] = 1'b1;
         end
         if (!ctrl.done) begin
            if (eff[EW-1:FRAME_LSB] >= FRAME_BITS'(TABLE_PAGES)) begin
               ctrl.done   = 1'b1;
               ctrl.status = ST_NOT_PRESENT;
            end else begin
               next_page = eff[FRAME_LSB +: PAGE_W];
            end
         end
         wr_entry = eff;
      end
   end

endmodule
